@@ rtl/core/cylinder_point_filter_macros.svh @@
// Assertion macros used by the checker of the cylinder point filter.
`ifndef CYLINDER_POINT_FILTER_MACROS_SVH
`define CYLINDER_POINT_FILTER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CPF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define CPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cpf_pkg.sv @@
// Package with the widths, types and register codes of the cylinder point filter.
package cpf_pkg;

	// Fixed-point formats of the coordinates and the axis.
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int AXIS_BITS  = FRAC_BITS + 2;
	localparam int LEN_BITS   = COORD_BITS - 1;
	localparam int NUM_AXES   = 3;

	// Widths of the intermediate results, each just wide enough for its range.
	localparam int OFF_W  = COORD_BITS + 1;
	localparam int PROD_W = OFF_W + AXIS_BITS;
	localparam int ACC_W  = PROD_W + 2;
	localparam int H_W    = ACC_W - FRAC_BITS;
	localparam int AXH_W  = AXIS_BITS + COORD_BITS;
	localparam int AXHS_W = AXH_W - FRAC_BITS;
	localparam int R_W    = AXHS_W + 1;
	localparam int SQ_W   = 2 * LEN_BITS;
	localparam int SUM_W  = SQ_W + 2;

	localparam int REG_IDX_W = 3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [AXIS_BITS-1:0]  axis_t;
	typedef logic [LEN_BITS-1:0]   len_t;
	typedef logic [OFF_W-1:0]      off_t;
	typedef logic [PROD_W-1:0]     prod_t;
	typedef logic [ACC_W-1:0]      acc_t;
	typedef logic [H_W-1:0]        h_t;
	typedef logic [AXH_W-1:0]      axh_t;
	typedef logic [R_W-1:0]        r_t;
	typedef logic [SQ_W-1:0]       sq_t;
	typedef logic [SUM_W-1:0]      sum_t;

	// Axis component of 1.0, the reset value of the z component.
	localparam axis_t AXIS_ONE = axis_t'(1) << FRAC_BITS;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTRE_X     = 3'd0,
		REG_CENTRE_Y     = 3'd1,
		REG_CENTRE_Z     = 3'd2,
		REG_AXIS_X       = 3'd3,
		REG_AXIS_Y       = 3'd4,
		REG_AXIS_Z       = 3'd5,
		REG_HALF_LENGTH  = 3'd6,
		REG_RADIUS       = 3'd7
	} reg_index_t;

	// Cylinder description as seen by the datapath.
	typedef struct packed {
		coord_t [NUM_AXES-1:0] centre;
		axis_t  [NUM_AXES-1:0] axis;
		len_t                  half_length;
		len_t                  radius;
		sq_t                   radius_sq;
	} cfg_t;

	// Item passed from the axial stages to the radial stages.
	typedef struct packed {
		coord_t [NUM_AXES-1:0] raw;
		off_t   [NUM_AXES-1:0] p;
		axh_t   [NUM_AXES-1:0] axh;
		logic                  far;
	} axial_t;

endpackage

@@ rtl/core/cpf_if.sv @@
// Stream interfaces for the input points and the kept points.
interface cpf_in_if;
	import cpf_pkg::*;

	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

interface cpf_out_if;
	import cpf_pkg::*;

	logic   valid;
	logic   ready;
	coord_t inside_x;
	coord_t inside_y;
	coord_t inside_z;

	modport source (output valid, output inside_x, output inside_y, output inside_z,
		input ready);
	modport sink (input valid, input inside_x, input inside_y, input inside_z,
		output ready);
endinterface

@@ rtl/core/cpf_config.sv @@
// Configuration registers of the cylinder and the derived radius square.
module cpf_config (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [cpf_pkg::COORD_BITS-1:0]  cfg_data,
	output cpf_pkg::cfg_t                   cfg
);
	import cpf_pkg::*;

	coord_t centre_q [NUM_AXES];
	axis_t  axis_q [NUM_AXES];
	len_t   half_length_q;
	len_t   radius_q;
	sq_t    radius_sq_q;

	// Register writes; bits above a register's width are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q[0]    <= '0;
			centre_q[1]    <= '0;
			centre_q[2]    <= '0;
			axis_q[0]      <= '0;
			axis_q[1]      <= '0;
			axis_q[2]      <= AXIS_ONE;
			half_length_q  <= '0;
			radius_q       <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_CENTRE_X:     centre_q[0]    <= cfg_data;
				REG_CENTRE_Y:     centre_q[1]    <= cfg_data;
				REG_CENTRE_Z:     centre_q[2]    <= cfg_data;
				REG_AXIS_X:       axis_q[0]      <= cfg_data[AXIS_BITS-1:0];
				REG_AXIS_Y:       axis_q[1]      <= cfg_data[AXIS_BITS-1:0];
				REG_AXIS_Z:       axis_q[2]      <= cfg_data[AXIS_BITS-1:0];
				REG_HALF_LENGTH:  half_length_q  <= cfg_data[LEN_BITS-1:0];
				REG_RADIUS:       radius_q       <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The radius square is registered and follows the radius in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_sq_q <= '0;
		end else begin
			radius_sq_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			cfg.centre[i] = centre_q[i];
			cfg.axis[i]   = axis_q[i];
		end
		cfg.half_length  = half_length_q;
		cfg.radius       = radius_q;
		cfg.radius_sq    = radius_sq_q;
	end
endmodule

@@ rtl/core/cpf_axial.sv @@
// Stages one to four: offset from the centre, axis products, projection on the axis, axial part and length test.
module cpf_axial (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cpf_pkg::cfg_t                           cfg,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  cpf_pkg::coord_t [cpf_pkg::NUM_AXES-1:0] in_pt,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output cpf_pkg::axial_t                         out_item
);
	import cpf_pkg::*;

	logic   v_s1, v_s2, v_s3, v_s4;
	logic   en_s1, en_s2, en_s3, en_s4;

	coord_t raw_s1 [NUM_AXES];
	coord_t raw_s2 [NUM_AXES];
	coord_t raw_s3 [NUM_AXES];
	coord_t raw_s4 [NUM_AXES];
	off_t   p_s1 [NUM_AXES];
	off_t   p_s2 [NUM_AXES];
	off_t   p_s3 [NUM_AXES];
	off_t   p_s4 [NUM_AXES];
	prod_t  prod_s2 [NUM_AXES];
	h_t     h_s3;
	axh_t   axh_s4 [NUM_AXES];
	logic   far_s4;

	acc_t   acc;
	h_t     hmag;
	logic   far;

	// A stage moves on when it is empty or when the next stage moves on.
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Sum of the three products, then the truncating shift down to h.
	assign acc = ACC_W'($signed(prod_s2[0])) + ACC_W'($signed(prod_s2[1]))
		+ ACC_W'($signed(prod_s2[2]));

	// Magnitude of h against the half length.
	assign hmag = h_s3[H_W-1] ? (-h_s3) : h_s3;
	assign far  = hmag > H_W'(cfg.half_length);

	always_ff @(posedge clk) begin
		// Stage one: offset of the point from the centre.
		if (en_s1) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s1[i] <= in_pt[i];
				p_s1[i]   <= OFF_W'($signed(in_pt[i])) - OFF_W'($signed(cfg.centre[i]));
			end
		end
		// Stage two: each offset component times its axis component.
		if (en_s2) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s2[i]  <= raw_s1[i];
				p_s2[i]    <= p_s1[i];
				prod_s2[i] <= PROD_W'($signed(p_s1[i])) * PROD_W'($signed(cfg.axis[i]));
			end
		end
		// Stage three: projection on the axis.
		if (en_s3) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s3[i] <= raw_s2[i];
				p_s3[i]   <= p_s2[i];
			end
			h_s3 <= acc[ACC_W-1:FRAC_BITS];
		end
		// Stage four: axial part of the offset and the length test. Where the item
		// is kept, h fits in a coordinate word.
		if (en_s4) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s4[i] <= raw_s3[i];
				p_s4[i]   <= p_s3[i];
				axh_s4[i] <= AXH_W'($signed(h_s3[COORD_BITS-1:0]))
					* AXH_W'($signed(cfg.axis[i]));
			end
			far_s4 <= far;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			out_item.raw[i] = raw_s4[i];
			out_item.p[i]   = p_s4[i];
			out_item.axh[i] = axh_s4[i];
		end
		out_item.far = far_s4;
	end
	assign out_valid = v_s4;
endmodule

@@ rtl/core/cpf_radial.sv @@
// Stages five to seven: radial offset, its square and the radius test.
module cpf_radial (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  cpf_pkg::cfg_t                            cfg,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  cpf_pkg::axial_t                          in_item,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output cpf_pkg::coord_t [cpf_pkg::NUM_AXES-1:0]  out_pt
);
	import cpf_pkg::*;

	logic   v_s5, v_s6, v_s7;
	logic   en_s5, en_s6, en_s7;

	coord_t raw_s5 [NUM_AXES];
	coord_t raw_s6 [NUM_AXES];
	coord_t raw_s7 [NUM_AXES];
	r_t     r_s5 [NUM_AXES];
	logic   far_s5;
	sq_t    sq_s6 [NUM_AXES];
	logic   drop_s6;
	sum_t   sum_s7;
	logic   drop_s7;

	r_t     rmag [NUM_AXES];
	logic   big [NUM_AXES];
	logic   keep;

	// A dropped item leaves stage seven without going to the output.
	assign keep      = !drop_s7 && (sum_s7 <= SUM_W'(cfg.radius_sq));
	assign out_valid = v_s7 && keep;
	assign en_s7     = !v_s7 || !keep || out_ready;
	assign en_s6     = !v_s6 || en_s7;
	assign en_s5     = !v_s5 || en_s6;
	assign in_ready  = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// Magnitude of each radial component. A component beyond the radius settles
	// the test on its own, so only the squares of components within it matter.
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			rmag[i] = r_s5[i][R_W-1] ? (-r_s5[i]) : r_s5[i];
			big[i]  = rmag[i] > R_W'(cfg.radius);
		end
	end

	always_ff @(posedge clk) begin
		// Stage five: remove the axial part from the offset.
		if (en_s5) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s5[i] <= in_item.raw[i];
				r_s5[i]   <= R_W'($signed(in_item.p[i]))
					- R_W'($signed(in_item.axh[i][AXH_W-1:FRAC_BITS]));
			end
			far_s5 <= in_item.far;
		end
		// Stage six: squares of the radial components.
		if (en_s6) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s6[i] <= raw_s5[i];
				sq_s6[i]  <= SQ_W'(rmag[i][LEN_BITS-1:0]) * SQ_W'(rmag[i][LEN_BITS-1:0]);
			end
			drop_s6 <= far_s5 || big[0] || big[1] || big[2];
		end
		// Stage seven: squared radial distance.
		if (en_s7) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_s7[i] <= raw_s6[i];
			end
			sum_s7  <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			drop_s7 <= drop_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			out_pt[i] = raw_s7[i];
		end
	end
endmodule

@@ rtl/core/cylinder_point_filter.sv @@
// Top level of the cylinder point filter: registers, datapath stages and output register.
//
// Takes one point per clock unless the stages are full behind a stalled output, and
// passes on, unchanged and in order, those inside the finite cylinder set by the
// centre, axis, half length and outer radius registers; the others are dropped. A
// kept point passes through seven datapath stages (offset, axis products, projection,
// axial part and length test, radial offset, radial squares, distance sum) and the
// output register. Each stage holds its item only while the stage after it is full
// and stalled, so empty slots close up and the input keeps taking points while a kept
// point waits at the output, until the stages are full. The radius square is derived
// from the outer radius register in the cycle after that register is written. Register
// indexes follow the list centre x, y, z, axis x, y, z, half length, outer radius.
module cylinder_point_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [cpf_pkg::COORD_BITS-1:0]  cfg_data,
	cpf_in_if.sink                          points,
	cpf_out_if.source                       kept
);
	import cpf_pkg::*;

	cfg_t                  cfg;
	coord_t [NUM_AXES-1:0] in_pt;
	logic                  ax_valid, ax_ready;
	axial_t                ax_item;
	logic                  rad_valid, rad_ready;
	coord_t [NUM_AXES-1:0] rad_pt;

	logic                  out_valid_q;
	coord_t                out_pt_q [NUM_AXES];
	logic                  en_out;

	cpf_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_pt[0] = points.point_x;
	assign in_pt[1] = points.point_y;
	assign in_pt[2] = points.point_z;

	cpf_axial u_axial (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (points.valid),
		.in_ready  (points.ready),
		.in_pt     (in_pt),
		.out_valid (ax_valid),
		.out_ready (ax_ready),
		.out_item  (ax_item)
	);

	cpf_radial u_radial (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (ax_valid),
		.in_ready  (ax_ready),
		.in_item   (ax_item),
		.out_valid (rad_valid),
		.out_ready (rad_ready),
		.out_pt    (rad_pt)
	);

	// Output register: loads whenever it is empty or its item is being taken.
	assign en_out    = !out_valid_q || kept.ready;
	assign rad_ready = en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= rad_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				out_pt_q[i] <= rad_pt[i];
			end
		end
	end

	assign kept.valid    = out_valid_q;
	assign kept.inside_x = out_pt_q[0];
	assign kept.inside_y = out_pt_q[1];
	assign kept.inside_z = out_pt_q[2];
endmodule

@@ rtl/core/cpf_checker.sv @@
// Port-level checker of the cylinder point filter and its bind to the top level.
`include "cylinder_point_filter_macros.svh"

module cpf_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [cpf_pkg::COORD_BITS-1:0] out_x,
	input  logic [cpf_pkg::COORD_BITS-1:0] out_y,
	input  logic [cpf_pkg::COORD_BITS-1:0] out_z
);
	import cpf_pkg::*;

	localparam int CREDIT_W = 16;

	logic                in_take;
	logic                out_take;
	logic                out_stall;
	logic [CREDIT_W-1:0] credit_q;

	assign in_take   = in_valid && in_ready;
	assign out_take  = out_valid && out_ready;
	assign out_stall = out_valid && !out_ready;

	// Items taken less items delivered; dropped items stay counted, so this only
	// bounds the outputs from above. Saturates at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (in_take && !out_take) begin
			if (credit_q != {CREDIT_W{1'b1}}) credit_q <= credit_q + 1'b1;
		end else if (!in_take && out_take) begin
			if (credit_q != '0) credit_q <= credit_q - 1'b1;
		end
	end

	`CPF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid, "kept item withdrawn while stalled")
	`CPF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(out_x) && $stable(out_y) && $stable(out_z), "kept item changed while stalled")
	`CPF_ASSERT(a_no_extra_item, clk, arst_n, out_take |-> (credit_q != '0), "more items delivered than taken")
	`CPF_ASSERT(a_ready_when_free, clk, arst_n, (!out_valid || out_ready) |-> in_ready, "input stalled while output is free")
endmodule

bind cylinder_point_filter cpf_checker u_cpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (kept.valid),
	.out_ready (kept.ready),
	.out_x     (kept.inside_x),
	.out_y     (kept.inside_y),
	.out_z     (kept.inside_z)
);
